FILE: rtl/core/slack_bounded_group_sort_unit_assert.svh
// Assertion helpers shared by the sort unit RTL.
// Each macro expects clk and rst_n in scope.
`ifndef SLACK_BOUNDED_GROUP_SORT_UNIT_ASSERT_SVH
`define SLACK_BOUNDED_GROUP_SORT_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SBGS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SBGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/sbgs_pkg.sv
package sbgs_pkg;

    localparam int GROUP_COUNT  = 16;
    // Must be a power of two: buffer slots wrap around a per-group head pointer.
    localparam int BUFFER_DEPTH = 16;

    localparam int GROUP_ID_W  = 4;
    localparam int KEY_W       = 64;
    localparam int PAY_W       = 64;
    localparam int SLACK_W     = 4;
    localparam int FMT_W       = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int CFG_INDEX_W = 1;

    localparam int GROUP_W     = $clog2(GROUP_COUNT);
    localparam int IDX_W       = $clog2(BUFFER_DEPTH);
    localparam int FILL_W      = $clog2(BUFFER_DEPTH + 1);
    localparam int ADDR_W      = GROUP_W + IDX_W;
    localparam int ENTRY_COUNT = GROUP_COUNT * BUFFER_DEPTH;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SLACK      = 1'b0,
        CFG_KEY_FORMAT = 1'b1
    } cfg_index_t;

    typedef enum logic [FMT_W-1:0] {
        FMT_INT    = 2'd0,
        FMT_SINGLE = 2'd1,
        FMT_DOUBLE = 2'd2
    } key_fmt_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } ram_wr_t;

endpackage

FILE: rtl/core/sbgs_if.sv
interface sbgs_item_if;
    logic                              valid;
    logic                              ready;
    logic [sbgs_pkg::GROUP_ID_W-1:0]   group_id;
    logic [sbgs_pkg::KEY_W-1:0]        sort_key;
    logic [sbgs_pkg::PAY_W-1:0]        payload;

    modport source (output valid, group_id, sort_key, payload, input ready);
    modport sink   (input valid, group_id, sort_key, payload, output ready);
endinterface

interface sbgs_result_if;
    logic                              valid;
    logic                              ready;
    logic [sbgs_pkg::GROUP_ID_W-1:0]   out_group;
    logic [sbgs_pkg::KEY_W-1:0]        out_key;
    logic [sbgs_pkg::PAY_W-1:0]        out_payload;

    modport source (output valid, out_group, out_key, out_payload, input ready);
    modport sink   (input valid, out_group, out_key, out_payload, output ready);
endinterface

FILE: rtl/core/sbgs_key_cmp.sv
module sbgs_key_cmp (
    input  logic [sbgs_pkg::KEY_W-1:0] key_a,
    input  logic [sbgs_pkg::KEY_W-1:0] key_b,
    input  sbgs_pkg::key_fmt_t         fmt,
    output logic                       a_less
);

    typedef struct packed {
        logic                       nan;
        logic [sbgs_pkg::KEY_W-1:0] rank;
    } rank_t;

    // Map raw key bits to an unsigned rank in compare order; flag NaN.
    function automatic rank_t key_rank(input logic [sbgs_pkg::KEY_W-1:0] k,
                                       input sbgs_pkg::key_fmt_t f);
        rank_t       r;
        logic [31:0] s;
        logic [63:0] d;
        begin
            r.nan  = 1'b0;
            r.rank = '0;
            s      = k[31:0];
            d      = k;
            case (f)
                sbgs_pkg::FMT_SINGLE:
                begin
                    r.nan = (s[30:23] == 8'hFF) && (s[22:0] != 23'd0);
                    if (s[30:0] == 31'd0)
                    begin
                        s = 32'd0;   // fold -0 onto +0
                    end
                    r.rank = {32'd0, (s[31] ? ~s : {1'b1, s[30:0]})};
                end
                sbgs_pkg::FMT_DOUBLE:
                begin
                    r.nan = (d[62:52] == 11'h7FF) && (d[51:0] != 52'd0);
                    if (d[62:0] == 63'd0)
                    begin
                        d = 64'd0;
                    end
                    r.rank = d[63] ? ~d : {1'b1, d[62:0]};
                end
                default:
                begin
                    r.rank = {~k[63], k[62:0]};
                end
            endcase
            return r;
        end
    endfunction

    rank_t rank_a;
    rank_t rank_b;

    assign rank_a = key_rank(key_a, fmt);
    assign rank_b = key_rank(key_b, fmt);

    // NaN sorts behind everything; NaNs tie among themselves.
    assign a_less = !rank_a.nan && (rank_b.nan || (rank_a.rank < rank_b.rank));

endmodule

FILE: rtl/core/sbgs_entry_ram.sv
module sbgs_entry_ram (
    input  logic                          clk,
    input  sbgs_pkg::ram_wr_t             wr,
    input  logic [sbgs_pkg::ADDR_W-1:0]   raddr,
    output sbgs_pkg::entry_t              rdata
);

    sbgs_pkg::entry_t mem [sbgs_pkg::ENTRY_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/slack_bounded_group_sort_unit.sv
// Per-group stable insertion sort with bounded slack. Each input beat carries a group,
// a 64-bit key and a 64-bit payload; the item is placed in its group's sorted buffer
// behind every held entry with an equal or smaller key, and once the group holds
// slack+1 entries the lowest one leaves on the result channel (at most one result per
// input beat). Keys compare as signed integers, IEEE single (low 32 bits) or IEEE
// double per key_format; NaNs go to the back and -0 equals +0. Held keys are compared
// under the key_format in force when the new item arrives. Flow: the block takes one
// input beat, then works on it alone with item.ready low. After the accept it looks up
// the group (ST_LOAD), then steps through each entry the group already holds (ST_SCAN),
// walking from the front with a single key comparator against a registered read of
// the entry RAM and moving every entry behind the insertion point one slot back, then
// writes the last entry (ST_PLACE), and when the item causes a result it fetches and
// presents the lowest entry (ST_FETCH, ST_EMIT). The return to ready can further wait
// while a previous result beat is unclaimed. The entry RAM needs no clearing pass;
// groups start empty after reset. Configuration writes go on the cfg_we/cfg_index/
// cfg_wdata port; the user must make them only while idle, which the block does not
// enforce itself.
`include "slack_bounded_group_sort_unit_assert.svh"

module slack_bounded_group_sort_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    sbgs_item_if.sink                           item,
    sbgs_result_if.source                       result,
    input  logic                                cfg_we,
    input  logic [sbgs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sbgs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_PLACE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    localparam int GW = sbgs_pkg::GROUP_W;
    localparam int IW = sbgs_pkg::IDX_W;
    localparam int FW = sbgs_pkg::FILL_W;

    // Highest count a group holds between items.
    localparam logic [FW-1:0] FILL_TOP = FW'(sbgs_pkg::BUFFER_DEPTH - 1);

    state_t                            state_reg, state_next;
    logic [GW-1:0]                     grp_reg, grp_next;
    logic [sbgs_pkg::KEY_W-1:0]        key_reg, key_next;
    sbgs_pkg::entry_t                  hold_reg, hold_next;
    logic                              found_reg, found_next;
    logic [IW-1:0]                     idx_reg, idx_next;
    logic [sbgs_pkg::SLACK_W-1:0]      slack_reg, slack_next;
    sbgs_pkg::key_fmt_t                fmt_reg, fmt_next;
    logic [FW-1:0]                     fill_reg [sbgs_pkg::GROUP_COUNT];
    logic [FW-1:0]                     fill_next [sbgs_pkg::GROUP_COUNT];
    logic [IW-1:0]                     head_reg [sbgs_pkg::GROUP_COUNT];
    logic [IW-1:0]                     head_next [sbgs_pkg::GROUP_COUNT];
    logic                              out_valid_reg, out_valid_next;
    logic [sbgs_pkg::GROUP_ID_W-1:0]   out_group_reg, out_group_next;
    sbgs_pkg::entry_t                  out_entry_reg, out_entry_next;

    logic [FW-1:0]                     fill_cur;
    logic [IW-1:0]                     head_cur;
    sbgs_pkg::ram_wr_t                 ram_wr;
    logic [sbgs_pkg::ADDR_W-1:0]       ram_raddr;
    sbgs_pkg::entry_t                  ram_rdata;
    logic                              new_less;
    logic                              emit_wait;

    // Physical slot of a logical buffer position: ring offset from the group's head.
    function automatic logic [sbgs_pkg::ADDR_W-1:0] slot_addr(input logic [GW-1:0] g,
                                                             input logic [IW-1:0] head,
                                                             input logic [IW-1:0] pos);
        logic [IW-1:0] ring;
        begin
            ring = head + pos;
            return {g, ring};
        end
    endfunction

    assign fill_cur     = fill_reg[grp_reg];
    assign head_cur     = head_reg[grp_reg];

    // Hold the emit step while the previous result beat is still unclaimed.
    assign emit_wait    = (state_reg == ST_EMIT) && out_valid_reg && !result.ready;

    assign item.ready   = (state_reg == ST_IDLE);

    assign result.valid       = out_valid_reg;
    assign result.out_group   = out_group_reg;
    assign result.out_key     = out_entry_reg.key;
    assign result.out_payload = out_entry_reg.payload;

    sbgs_entry_ram u_ram (
        .clk   (clk),
        .wr    (ram_wr),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared comparator: new key against the entry read back in the previous cycle.
    sbgs_key_cmp u_cmp (
        .key_a  (key_reg),
        .key_b  (ram_rdata.key),
        .fmt    (fmt_reg),
        .a_less (new_less)
    );

    always_comb
    begin
        state_next     = state_reg;
        grp_next       = grp_reg;
        key_next       = key_reg;
        hold_next      = hold_reg;
        found_next     = found_reg;
        idx_next       = idx_reg;
        slack_next     = slack_reg;
        fmt_next       = fmt_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        out_group_next = out_group_reg;
        out_entry_next = out_entry_reg;
        ram_wr         = '0;
        ram_raddr      = slot_addr(grp_reg, head_cur, idx_reg - IW'(1));

        // Drop the result beat once taken.
        out_valid_next = out_valid_reg && !result.ready;

        if (cfg_we)
        begin
            unique case (sbgs_pkg::cfg_index_t'(cfg_index))
                sbgs_pkg::CFG_SLACK:
                begin
                    slack_next = cfg_wdata[sbgs_pkg::SLACK_W-1:0];
                end
                sbgs_pkg::CFG_KEY_FORMAT:
                begin
                    fmt_next = sbgs_pkg::key_fmt_t'(cfg_wdata[sbgs_pkg::FMT_W-1:0]);
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    grp_next          = item.group_id[GW-1:0];
                    key_next          = item.sort_key;
                    hold_next.key     = item.sort_key;
                    hold_next.payload = item.payload;
                    found_next        = 1'b0;
                    // Groups outside the configured range are swallowed.
                    if (32'(item.group_id) < sbgs_pkg::GROUP_COUNT)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                idx_next = '0;
                if (fill_cur == '0)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    // Start at the front: read the lowest held entry.
                    ram_raddr  = slot_addr(grp_reg, head_cur, '0);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // The new item lands before the first entry it beats; from there on
                // every entry moves one slot back, carried through the hold register.
                if (found_reg || new_less)
                begin
                    ram_wr.en   = 1'b1;
                    ram_wr.addr = slot_addr(grp_reg, head_cur, idx_reg);
                    ram_wr.data = hold_reg;
                    hold_next   = ram_rdata;
                    found_next  = 1'b1;
                end
                idx_next = idx_reg + IW'(1);
                if (FW'(idx_reg) == fill_cur - FW'(1))
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    ram_raddr = slot_addr(grp_reg, head_cur, idx_reg + IW'(1));
                end
            end
            ST_PLACE:
            begin
                // Write the new item or the carried last entry behind the others.
                ram_wr.en   = 1'b1;
                ram_wr.addr = slot_addr(grp_reg, head_cur, idx_reg);
                ram_wr.data = hold_reg;
                if (fill_cur >= FW'(slack_reg))
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    fill_next[grp_reg] = fill_cur + FW'(1);
                    state_next         = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                ram_raddr  = slot_addr(grp_reg, head_cur, '0);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Keep the front read alive so the data holds while the output is busy.
                ram_raddr = slot_addr(grp_reg, head_cur, '0);
                if (!emit_wait)
                begin
                    out_valid_next     = 1'b1;
                    out_group_next     = sbgs_pkg::GROUP_ID_W'(grp_reg);
                    out_entry_next     = ram_rdata;
                    // Pop the front: advance the head, fill count is unchanged.
                    head_next[grp_reg] = head_cur + IW'(1);
                    state_next         = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            grp_reg       <= '0;
            key_reg       <= '0;
            hold_reg      <= '0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
            slack_reg     <= '0;
            fmt_reg       <= sbgs_pkg::FMT_INT;
            out_valid_reg <= 1'b0;
            out_group_reg <= '0;
            out_entry_reg <= '0;
            for (int g = 0; g < sbgs_pkg::GROUP_COUNT; g++)
            begin
                fill_reg[g] <= '0;
                head_reg[g] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            grp_reg       <= grp_next;
            key_reg       <= key_next;
            hold_reg      <= hold_next;
            found_reg     <= found_next;
            idx_reg       <= idx_next;
            slack_reg     <= slack_next;
            fmt_reg       <= fmt_next;
            out_valid_reg <= out_valid_next;
            out_group_reg <= out_group_next;
            out_entry_reg <= out_entry_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
        end
    end

    `SBGS_ASSERT_IMPL(a_fill_bound, state_reg != ST_IDLE, fill_cur <= FILL_TOP, "fill past depth")
    `SBGS_ASSERT_IMPL(a_scan_range, state_reg == ST_SCAN, FW'(idx_reg) < fill_cur, "scan overrun")
    `SBGS_ASSERT_NEXT(a_emit_hold, emit_wait, state_reg == ST_EMIT, "emit left while busy")
    `SBGS_ASSERT_NEXT(a_busy_after_take, state_next == ST_LOAD, !item.ready, "ready while busy")

endmodule
